@@ hw/rtl/rem_pkg.sv @@
`default_nettype none
package rem_pkg;

  // Field widths fixed by the register map
  localparam int CX_BITS       = 20;
  localparam int TRIG_BITS     = 18;
  localparam int RECIP_BITS    = 32;
  localparam int BLANK_BITS    = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int MASK_BITS     = 2;

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_COS_ANGLE    = 3'd2,
    REG_SIN_ANGLE    = 3'd3,
    REG_INV_MAJOR_SQ = 3'd4,
    REG_INV_MINOR_SQ = 3'd5,
    REG_BLANK_VALUE  = 3'd6
  } cfg_idx_t;

  // Mask codes
  localparam logic [MASK_BITS-1:0] MASK_INSIDE   = 2'd0;
  localparam logic [MASK_BITS-1:0] MASK_OUTSIDE  = 2'd1;
  localparam logic [MASK_BITS-1:0] MASK_POSITIVE = 2'd2;

  // Reset value of the cosine: exactly one in Q1.16
  localparam logic signed [TRIG_BITS-1:0] COS_RESET = 18'sd65536;

  typedef struct packed {
    logic        [CX_BITS-1:0]    center_x;
    logic        [CX_BITS-1:0]    center_y;
    logic signed [TRIG_BITS-1:0]  cos_angle;
    logic signed [TRIG_BITS-1:0]  sin_angle;
    logic        [RECIP_BITS-1:0] inv_major_sq;
    logic        [RECIP_BITS-1:0] inv_minor_sq;
    logic        [BLANK_BITS-1:0] blank_value;
  } rem_cfg_t;

  // Pixel classification carried alongside the geometry
  typedef struct packed {
    logic positive;
    logic blank;
  } pix_flags_t;

endpackage
`default_nettype wire

@@ hw/rtl/rem_ifs.sv @@
`default_nettype none
interface rem_pix_if #(
  parameter int PIXEL_BITS = 32,
  parameter int COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel_value;
  logic        [COORD_BITS-1:0] column;
  logic        [COORD_BITS-1:0] row;

  modport source (output valid, pixel_value, column, row, input ready);
  modport sink   (input valid, pixel_value, column, row, output ready);
endinterface

interface rem_mask_if import rem_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MASK_BITS-1:0] mask_code;

  modport source (output valid, mask_code, input ready);
  modport sink   (input valid, mask_code, output ready);
endinterface

interface rem_cfg_if import rem_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rem_cfg_regs.sv @@
`default_nettype none
module rem_cfg_regs import rem_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rem_cfg_if.sink    cfg_wr,
  output rem_cfg_t   regs
);

  rem_cfg_t regs_r;
  logic     wr_fire;

  // Always take a write
  assign cfg_wr.ready = 1'b1;
  assign wr_fire      = cfg_wr.valid && cfg_wr.ready;
  assign regs         = regs_r;

  // Decode the index; drop writes beyond the map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.center_x     <= '0;
      regs_r.center_y     <= '0;
      regs_r.cos_angle    <= COS_RESET;
      regs_r.sin_angle    <= '0;
      regs_r.inv_major_sq <= '0;
      regs_r.inv_minor_sq <= '0;
      regs_r.blank_value  <= '0;
    end else if (wr_fire) begin
      case (cfg_idx_t'(cfg_wr.index))
        REG_CENTER_X:     regs_r.center_x     <= cfg_wr.data[CX_BITS-1:0];
        REG_CENTER_Y:     regs_r.center_y     <= cfg_wr.data[CX_BITS-1:0];
        REG_COS_ANGLE:    regs_r.cos_angle    <= $signed(cfg_wr.data[TRIG_BITS-1:0]);
        REG_SIN_ANGLE:    regs_r.sin_angle    <= $signed(cfg_wr.data[TRIG_BITS-1:0]);
        REG_INV_MAJOR_SQ: regs_r.inv_major_sq <= cfg_wr.data[RECIP_BITS-1:0];
        REG_INV_MINOR_SQ: regs_r.inv_minor_sq <= cfg_wr.data[RECIP_BITS-1:0];
        REG_BLANK_VALUE:  regs_r.blank_value  <= cfg_wr.data[BLANK_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/rotated_ellipse_pixel_mask_top.sv @@
// Each accepted pixel passes through the stages in order; its mask code is held in the final stage register.
// Throughput: one pixel per cycle, set by the eight-stage register pipeline
// (offset, rotate multiply, rotate sum, round, square, weight multiply,
// partial sums, final compare); a stalled output holds stages, bubbles close up.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register
// defaults: center 0, cosine one, sine 0, reciprocals 0, blank value 0.
`default_nettype none
module rotated_ellipse_pixel_mask_top import rem_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int PIXEL_BITS = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  rem_pix_if.sink    in_pix,
  rem_mask_if.source out_mask,
  rem_cfg_if.sink    cfg_wr
);

  localparam int NSTG = 8;
  localparam int LAST = NSTG - 1;
  localparam int DXW  = ((COORD_BITS + 8) > CX_BITS ? COORD_BITS + 8 : CX_BITS) + 1;
  localparam int PW   = DXW + TRIG_BITS;
  localparam int UW   = PW + 1;
  localparam int MW   = UW - 16;
  localparam int SW   = 2 * MW;
  localparam int PPW  = MW + RECIP_BITS;
  localparam int HSW  = PPW + 1;
  localparam int TW   = SW + RECIP_BITS + 1;
  localparam logic [UW-1:0] RND_HALF = UW'(32768);
  localparam logic [TW-1:0] ONE_Q48  = TW'(64'h0001_0000_0000_0000);

  rem_cfg_t cfg;

  rem_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .regs   (cfg)
  );

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;
  logic            in_fire;

  // Stage advances when it is empty or the stage after it advances
  always_comb begin
    en[LAST] = !v_r[LAST] || out_mask.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_pix.ready = en[0];
  assign in_fire      = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_fire;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 0: offsets from center, pixel classification
  logic        [COORD_BITS-1:0] col, row;
  logic signed [PIXEL_BITS-1:0] pix, blk;
  logic signed [DXW-1:0]        dx_nxt, dy_nxt, dx_r, dy_r;
  pix_flags_t                   fl_nxt;
  pix_flags_t                   fl_r [LAST];

  assign col    = in_pix.column;
  assign row    = in_pix.row;
  assign pix    = in_pix.pixel_value;
  assign blk    = $signed(cfg.blank_value[PIXEL_BITS-1:0]);
  assign dx_nxt = $signed(DXW'({col, 8'h00}) - DXW'(cfg.center_x));
  assign dy_nxt = $signed(DXW'({row, 8'h00}) - DXW'(cfg.center_y));
  assign fl_nxt.blank    = (pix == blk);
  assign fl_nxt.positive = !pix[PIXEL_BITS-1] && (pix != '0) && !fl_nxt.blank;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      fl_r[0]  <= fl_nxt;
    end
    for (int k = 1; k < LAST; k++) begin
      if (en[k]) begin
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  // Stage 1: rotation products
  logic signed [PW-1:0] pux_nxt, puy_nxt, pvy_nxt, pvx_nxt;
  logic signed [PW-1:0] pux_r, puy_r, pvy_r, pvx_r;

  assign pux_nxt = PW'(dx_r) * PW'(cfg.cos_angle);
  assign puy_nxt = PW'(dy_r) * PW'(cfg.sin_angle);
  assign pvy_nxt = PW'(dy_r) * PW'(cfg.cos_angle);
  assign pvx_nxt = PW'(dx_r) * PW'(cfg.sin_angle);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pux_r <= pux_nxt;
      puy_r <= puy_nxt;
      pvy_r <= pvy_nxt;
      pvx_r <= pvx_nxt;
    end
  end

  // Stage 2: rotated offsets in Q.24
  logic signed [UW-1:0] u_nxt, v_nxt, u_r, v_r2;

  assign u_nxt = UW'(pux_r) + UW'(puy_r);
  assign v_nxt = UW'(pvy_r) - UW'(pvx_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      u_r  <= u_nxt;
      v_r2 <= v_nxt;
    end
  end

  // Stage 3: magnitude rounded to Q.8, halves away from zero
  logic [UW-1:0] au, av, au_rnd, av_rnd;
  logic [MW-1:0] mu_nxt, mv_nxt, mu_r, mv_r;

  assign au     = u_r[UW-1]  ? UW'(-u_r)  : UW'(u_r);
  assign av     = v_r2[UW-1] ? UW'(-v_r2) : UW'(v_r2);
  assign au_rnd = au + RND_HALF;
  assign av_rnd = av + RND_HALF;
  assign mu_nxt = au_rnd[UW-1:16];
  assign mv_nxt = av_rnd[UW-1:16];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      mu_r <= mu_nxt;
      mv_r <= mv_nxt;
    end
  end

  // Stage 4: squares in Q.16
  logic [SW-1:0] sqa_nxt, sqb_nxt, sqa_r, sqb_r;

  assign sqa_nxt = SW'(mu_r) * SW'(mu_r);
  assign sqb_nxt = SW'(mv_r) * SW'(mv_r);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sqa_r <= sqa_nxt;
      sqb_r <= sqb_nxt;
    end
  end

  // Stage 5: weight each square half by its reciprocal
  logic [PPW-1:0] pah_nxt, pal_nxt, pbh_nxt, pbl_nxt;
  logic [PPW-1:0] pah_r, pal_r, pbh_r, pbl_r;

  assign pah_nxt = PPW'(sqa_r[SW-1:MW]) * PPW'(cfg.inv_major_sq);
  assign pal_nxt = PPW'(sqa_r[MW-1:0])  * PPW'(cfg.inv_major_sq);
  assign pbh_nxt = PPW'(sqb_r[SW-1:MW]) * PPW'(cfg.inv_minor_sq);
  assign pbl_nxt = PPW'(sqb_r[MW-1:0])  * PPW'(cfg.inv_minor_sq);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      pah_r <= pah_nxt;
      pal_r <= pal_nxt;
      pbh_r <= pbh_nxt;
      pbl_r <= pbl_nxt;
    end
  end

  // Stage 6: sum the upper and lower partial products
  logic [HSW-1:0] hsum_nxt, lsum_nxt, hsum_r, lsum_r;

  assign hsum_nxt = HSW'(pah_r) + HSW'(pbh_r);
  assign lsum_nxt = HSW'(pal_r) + HSW'(pbl_r);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      hsum_r <= hsum_nxt;
      lsum_r <= lsum_nxt;
    end
  end

  // Stage 7: compare the weighted sum with one and form the code
  logic [TW-1:0]        total;
  logic                 in_ellipse;
  logic [MASK_BITS-1:0] code_nxt, code_r;

  assign total      = (TW'(hsum_r) << MW) + TW'(lsum_r);
  assign in_ellipse = (total <= ONE_Q48);

  always_comb begin
    if (fl_r[LAST-1].positive) begin
      code_nxt = MASK_POSITIVE;
    end else if (in_ellipse || fl_r[LAST-1].blank) begin
      code_nxt = MASK_INSIDE;
    end else begin
      code_nxt = MASK_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      code_r <= code_nxt;
    end
  end

  assign out_mask.valid     = v_r[LAST];
  assign out_mask.mask_code = code_r;

  // An accepted pixel always lands in the first stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v_r[0])
    else $error("accepted pixel not captured in first stage");

  // A full stage behind the stalled output stage keeps its item
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[LAST-1] && v_r[LAST] && !out_mask.ready) |=> (v_r[LAST-1] && v_r[LAST]))
    else $error("pipeline item dropped under stall");

  // Only defined codes leave the block
  a_code_defined: assert property (@(posedge clk) disable iff (!rst_n)
    out_mask.valid |-> (code_r <= MASK_POSITIVE))
    else $error("undefined mask code");

  // A result waiting at the output keeps its code
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[LAST] && !out_mask.ready) |=> $stable(code_r))
    else $error("stalled mask code changed");

endmodule
`default_nettype wire
